// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

// ----- rtl/core/plce_pkg.sv -----
// Shared types and constants of the piecewise-linear curve evaluator.
// No dependencies; every other file of the block but assert_macros.svh refers to it by scope.
`timescale 1ns / 1ps

package plce_pkg;

  localparam int NUM_KNOTS = 10;
  localparam int KIDX_W    = $clog2(NUM_KNOTS);
  localparam logic [KIDX_W-1:0] LAST_IDX = KIDX_W'(NUM_KNOTS - 1);

  // front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // evaluates that can be in flight: queue, back end, output register
  localparam int PEND_MAX = QDEPTH + 2;
  localparam int PEND_W   = $clog2(PEND_MAX + 1);

  // divider: 48-bit dividend, two quotient bits per cycle
  localparam int PROD_W    = 48;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = PROD_W / DIV_BITS;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  typedef enum logic {
    OP_EVAL = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KIDX_W-1:0] slot;
    logic [15:0]       coord;
    logic [15:0]       value;
    logic [31:0]       target;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_FINISH
  } back_state_t;

endpackage

// ----- rtl/core/plce_div.sv -----
// Iterative unsigned divider, 48-bit dividend by 16-bit divisor, two bits per cycle.
// Depends on plce_pkg for widths and step count.
`timescale 1ns / 1ps

module plce_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [plce_pkg::PROD_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       done,
  output logic [plce_pkg::PROD_W-1:0] quotient
);

  logic                        busy_r;
  logic                        done_r;
  logic [plce_pkg::DIVC_W-1:0] cnt_r;
  logic [plce_pkg::PROD_W-1:0] quo_r;
  logic [15:0]                 rem_r;
  logic [15:0]                 dsr_r;

  logic [15:0]                 rem_w  [0:plce_pkg::DIV_BITS];
  logic [plce_pkg::PROD_W-1:0] quo_w  [0:plce_pkg::DIV_BITS];
  logic [16:0]                 part_w [0:plce_pkg::DIV_BITS-1];
  logic [16:0]                 diff_w [0:plce_pkg::DIV_BITS-1];

  // restoring steps; the quotient bits shift in where dividend bits leave
  always_comb begin
    rem_w[0] = rem_r;
    quo_w[0] = quo_r;
    for (int j = 0; j < plce_pkg::DIV_BITS; j++) begin
      part_w[j] = {rem_w[j], quo_w[j][plce_pkg::PROD_W-1]};
      diff_w[j] = part_w[j] - {1'b0, dsr_r};
      if (part_w[j] >= {1'b0, dsr_r}) begin
        rem_w[j+1] = diff_w[j][15:0];
        quo_w[j+1] = {quo_w[j][plce_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_w[j+1] = part_w[j][15:0];
        quo_w[j+1] = {quo_w[j][plce_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == plce_pkg::DIVC_W'(plce_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_w[plce_pkg::DIV_BITS];
      rem_r <= rem_w[plce_pkg::DIV_BITS];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/plce_front.sv -----
// Input side: accepts beats, drops loads to slots past the last knot, queues the rest.
// Depends on plce_pkg for the item type and queue depth.
`timescale 1ns / 1ps

module plce_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_action,
  input  logic [3:0]                   in_knot_slot,
  input  logic [15:0]                  in_knot_coord,
  input  logic [15:0]                  in_knot_value,
  input  logic [31:0]                  in_target,
  output logic                         q_empty,
  output plce_pkg::item_t              q_item,
  input  logic                         q_pop
);

  plce_pkg::item_t             qmem [0:plce_pkg::QDEPTH-1];
  logic [plce_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [plce_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [plce_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  logic            accept;
  logic            slot_ok;
  logic            keep;
  plce_pkg::op_t   op;
  plce_pkg::item_t item;

  assign op      = plce_pkg::op_t'(in_action);
  assign slot_ok = int'(in_knot_slot) < plce_pkg::NUM_KNOTS;
  assign accept  = push && !full;
  assign keep    = accept && ((op == plce_pkg::OP_EVAL) || slot_ok);

  always_comb begin
    item.op     = op;
    item.slot   = plce_pkg::KIDX_W'(in_knot_slot);
    item.coord  = in_knot_coord;
    item.value  = in_knot_value;
    item.target = in_target;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (keep) begin
      wr_ptr_nxt = (wr_ptr_r == plce_pkg::QPTR_W'(plce_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == plce_pkg::QPTR_W'(plce_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (keep && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!keep && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      qmem[wr_ptr_r] <= item;
    end
  end

  assign full    = cnt_r == plce_pkg::QCNT_W'(plce_pkg::QDEPTH);
  assign q_empty = cnt_r == '0;
  assign q_item  = qmem[rd_ptr_r];

endmodule

// ----- rtl/core/plce_back.sv -----
// Execution side: knot store, knot scan, multiply, divide and the output register.
// Depends on plce_pkg and plce_div.
`timescale 1ns / 1ps

module plce_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata,
  input  logic                   q_empty,
  input  plce_pkg::item_t        q_item,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [15:0]            out_curve_value,
  output logic                   out_zero_width_segment
);

  plce_pkg::back_state_t state_r, state_nxt;

  logic [3:0]  shift_r;
  logic [31:0] t_r;

  // knot store, one read port
  logic [15:0] cmem [0:plce_pkg::NUM_KNOTS-1];
  logic [15:0] vmem [0:plce_pkg::NUM_KNOTS-1];
  logic [15:0] cd_r, vd_r;
  logic        mem_we, rd_en;

  logic [plce_pkg::KIDX_W-1:0] rd_idx_r, pk_idx_r;
  logic        iss_done_r, pk_vld_r;

  logic        prev_ge_r, lo_clamp_r, found_r;
  logic [15:0] prev_c_r, prev_v_r, vfirst_r;
  logic [15:0] c1_r, c2_r, v1_r, v2_r;

  logic [15:0] span_r, dv_r;
  logic [31:0] dist_r;
  logic        rise_r;
  logic [plce_pkg::PROD_W-1:0] prod_r;

  logic [15:0] res_r;
  logic        zf_r;
  logic        out_vld_r;
  logic [15:0] out_val_r;
  logic        out_zf_r;

  logic        eval_go, scan_last, clamp_hit, out_free;
  logic        div_start, div_done;
  logic [plce_pkg::PROD_W-1:0] div_q;

  logic [31:0] scaled, st, c1_ext;
  logic        t_ge_s, s_ge_t, brk;
  logic [15:0] span, dv, res_div;
  logic [plce_pkg::PROD_W:0] sum_up;

  assign scaled = {16'b0, cd_r} << shift_r;
  assign t_ge_s = t_r >= scaled;
  assign s_ge_t = scaled >= t_r;
  assign brk    = prev_ge_r && s_ge_t;

  assign st     = t_r >> shift_r;
  assign c1_ext = {16'b0, c1_r};
  assign span   = (c2_r >= c1_r) ? c2_r - c1_r : c1_r - c2_r;
  assign dv     = (v2_r >= v1_r) ? v2_r - v1_r : v1_r - v2_r;

  assign sum_up = {1'b0, div_q} + (plce_pkg::PROD_W + 1)'(v1_r);
  always_comb begin
    if (rise_r) begin
      res_div = (sum_up > (plce_pkg::PROD_W + 1)'(16'hFFFF)) ? 16'hFFFF : sum_up[15:0];
    end else begin
      res_div = (div_q >= plce_pkg::PROD_W'(v1_r)) ? 16'h0000 : v1_r - div_q[15:0];
    end
  end

  assign scan_last = (state_r == plce_pkg::ST_SCAN) && pk_vld_r && (pk_idx_r == plce_pkg::LAST_IDX);
  assign clamp_hit = lo_clamp_r || t_ge_s;
  assign out_free  = !out_vld_r || pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plce_pkg::ST_IDLE: begin
        if (!q_empty && (q_item.op == plce_pkg::OP_EVAL)) state_nxt = plce_pkg::ST_SCAN;
      end
      plce_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = clamp_hit ? plce_pkg::ST_FINISH : plce_pkg::ST_PREP;
      end
      plce_pkg::ST_PREP: begin
        state_nxt = (span == 16'h0000) ? plce_pkg::ST_FINISH : plce_pkg::ST_MUL;
      end
      plce_pkg::ST_MUL:   state_nxt = plce_pkg::ST_DIVGO;
      plce_pkg::ST_DIVGO: state_nxt = plce_pkg::ST_DIV;
      plce_pkg::ST_DIV: begin
        if (div_done) state_nxt = plce_pkg::ST_FINISH;
      end
      plce_pkg::ST_FINISH: begin
        if (out_free) state_nxt = plce_pkg::ST_IDLE;
      end
      default: state_nxt = plce_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      plce_pkg::ST_IDLE:  q_pop     = !q_empty;
      plce_pkg::ST_SCAN:  rd_en     = !iss_done_r;
      plce_pkg::ST_DIVGO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign mem_we  = q_pop && (q_item.op == plce_pkg::OP_LOAD);
  assign eval_go = q_pop && (q_item.op == plce_pkg::OP_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= plce_pkg::ST_IDLE;
      shift_r    <= '0;
      iss_done_r <= 1'b0;
      pk_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) shift_r <= cfg_wdata;
      if (eval_go) begin
        iss_done_r <= 1'b0;
        pk_vld_r   <= 1'b0;
      end else begin
        pk_vld_r <= rd_en;
        if (rd_en && (rd_idx_r == plce_pkg::LAST_IDX)) iss_done_r <= 1'b1;
      end
      if ((state_r == plce_pkg::ST_FINISH) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cmem[q_item.slot] <= q_item.coord;
      vmem[q_item.slot] <= q_item.value;
    end
    if (rd_en) begin
      cd_r <= cmem[rd_idx_r];
      vd_r <= vmem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      t_r      <= q_item.target;
      rd_idx_r <= '0;
      found_r  <= 1'b0;
    end
    if (rd_en) begin
      pk_idx_r <= rd_idx_r;
      if (rd_idx_r != plce_pkg::LAST_IDX) rd_idx_r <= rd_idx_r + 1'b1;
    end

    // one knot per beat of the read port; segment 0 is the fallback
    if ((state_r == plce_pkg::ST_SCAN) && pk_vld_r) begin
      prev_ge_r <= t_ge_s;
      prev_c_r  <= cd_r;
      prev_v_r  <= vd_r;
      if (pk_idx_r == '0) begin
        lo_clamp_r <= s_ge_t;
        vfirst_r   <= vd_r;
        c1_r       <= cd_r;
        v1_r       <= vd_r;
      end else if (pk_idx_r == plce_pkg::KIDX_W'(1)) begin
        c2_r    <= cd_r;
        v2_r    <= vd_r;
        found_r <= brk;
      end else if (!found_r && brk) begin
        c1_r    <= prev_c_r;
        v1_r    <= prev_v_r;
        c2_r    <= cd_r;
        v2_r    <= vd_r;
        found_r <= 1'b1;
      end
      if (scan_last) begin
        res_r <= lo_clamp_r ? vfirst_r : vd_r;
        zf_r  <= 1'b0;
      end
    end

    if (state_r == plce_pkg::ST_PREP) begin
      span_r <= span;
      dv_r   <= dv;
      rise_r <= v2_r >= v1_r;
      dist_r <= (c1_ext >= st) ? c1_ext - st : st - c1_ext;
      res_r  <= v1_r;
      zf_r   <= span == 16'h0000;
    end

    if (state_r == plce_pkg::ST_MUL) begin
      prod_r <= plce_pkg::PROD_W'(dv_r) * plce_pkg::PROD_W'(dist_r);
    end

    if ((state_r == plce_pkg::ST_DIV) && div_done) begin
      res_r <= res_div;
    end

    if ((state_r == plce_pkg::ST_FINISH) && out_free) begin
      out_val_r <= res_r;
      out_zf_r  <= zf_r;
    end
  end

  plce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign empty                  = !out_vld_r;
  assign out_curve_value        = out_val_r;
  assign out_zero_width_segment = out_zf_r;

endmodule

// ----- rtl/core/piecewise_linear_curve_eval.sv -----
// Piecewise-linear curve evaluator over ten knots. Load beats write one knot
// (coordinate, value). The execution side retires one load per cycle while it
// is idle, writing each from the queue into the knot store. Loads to slots
// past the last knot are dropped. An evaluate beat that lands inside a segment
// passes from accept to result through these steps:
//   - it leaves the queue;
//   - knot scan, one knot per cycle through the store's single read port;
//   - a setup step, a multiply step and a divider start step;
//   - the divider: 24 steps of two quotient bits, then done;
//   - the output register is loaded.
// Evaluates clamped to an end knot skip the arithmetic. Zero-width segments
// skip the multiply and the divide. Evaluates run one at a time; the next
// queued beat leaves the queue the cycle after a result is registered. A
// result that is not popped holds the execution side in its last cycle. A
// two-deep queue sits between the input and the execution side, and
// one output register holds a result until popped. The knot store has no reset;
// evaluating before every knot is loaded gives an undefined result.
// Depends on plce_pkg, plce_front, plce_back.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [3:0]  in_knot_slot,
  input  logic [15:0] in_knot_coord,
  input  logic [15:0] in_knot_value,
  input  logic [31:0] in_target,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_curve_value,
  output logic        out_zero_width_segment
);

  logic            q_empty;
  logic            q_pop;
  plce_pkg::item_t q_item;

  plce_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_knot_slot  (in_knot_slot),
    .in_knot_coord (in_knot_coord),
    .in_knot_value (in_knot_value),
    .in_target     (in_target),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  plce_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .q_empty                (q_empty),
    .q_item                 (q_item),
    .q_pop                  (q_pop),
    .pop                    (pop),
    .empty                  (empty),
    .out_curve_value        (out_curve_value),
    .out_zero_width_segment (out_zero_width_segment)
  );

endmodule

// ----- rtl/core/plce_checker.sv -----
// Port-level checker for the curve evaluator, attached to the top level by bind.
// Depends on plce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_action,
  input logic        pop,
  input logic        empty,
  input logic [15:0] out_curve_value,
  input logic        out_zero_width_segment
);

  // evaluate beats accepted but not yet popped
  logic [plce_pkg::PEND_W-1:0] pend_r;
  logic                        eval_in, res_out;

  assign eval_in = push && !full && (plce_pkg::op_t'(in_action) == plce_pkg::OP_EVAL);
  assign res_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (eval_in && !res_out) begin
      pend_r <= pend_r + 1'b1;
    end else if (!eval_in && res_out) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  `ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_curve_value) && $stable(out_zero_width_segment))
  `ASSERT_SAME(a_no_phantom_result, !empty, pend_r != '0)
  `ASSERT_ALWAYS(a_inflight_bound, pend_r <= plce_pkg::PEND_W'(plce_pkg::PEND_MAX))

endmodule

bind piecewise_linear_curve_eval plce_checker u_plce_checker (.*);

// ----- tb/plce_curve_checker.sv -----
// Scoreboard for the piecewise-linear curve evaluator: mirrors the knot store
// and the scale register, predicts every evaluate beat and checks popped beats.
// Depends on plce_pkg.
`timescale 1ns / 1ps

module plce_curve_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        push,
  input  logic        full,
  input  logic        in_action,
  input  logic [3:0]  in_knot_slot,
  input  logic [15:0] in_knot_coord,
  input  logic [15:0] in_knot_value,
  input  logic [31:0] in_target,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_curve_value,
  input  logic        out_zero_width_segment,
  output int          fail_count,
  output int          results_checked,
  output int          results_owed
);

  typedef struct packed {
    logic [15:0] curve_value;
    logic        zero_width;
  } curve_point_t;

  logic [15:0]  knot_x [plce_pkg::NUM_KNOTS];
  logic [15:0]  knot_y [plce_pkg::NUM_KNOTS];
  logic [3:0]   scale_shift;
  curve_point_t owed_q [$];

  function automatic logic [63:0] scaled_x(input int i);
    return {48'd0, knot_x[i]} << scale_shift;
  endfunction

  function automatic curve_point_t predict_curve(input logic [31:0] target);
    curve_point_t p;
    logic [63:0]  t, st, x1, x2, y1, y2, span, reach, q, res;
    int           seg;
    bit           hit;
    p.zero_width = 1'b0;
    t = {32'd0, target};
    if (scaled_x(0) >= t) begin
      p.curve_value = knot_y[0];
      return p;
    end
    if (t >= scaled_x(plce_pkg::NUM_KNOTS - 1)) begin
      p.curve_value = knot_y[plce_pkg::NUM_KNOTS - 1];
      return p;
    end
    // lowest segment whose scaled ends bracket the target, else segment 0
    seg = 0;
    hit = 1'b0;
    for (int i = 0; i < plce_pkg::NUM_KNOTS - 1; i++) begin
      if (!hit && t >= scaled_x(i) && scaled_x(i + 1) >= t) begin
        seg = i;
        hit = 1'b1;
      end
    end
    x1 = {48'd0, knot_x[seg]};
    x2 = {48'd0, knot_x[seg + 1]};
    y1 = {48'd0, knot_y[seg]};
    y2 = {48'd0, knot_y[seg + 1]};
    st = t >> scale_shift;
    span = (x2 >= x1) ? x2 - x1 : x1 - x2;
    if (span == 0) begin
      p.curve_value = y1[15:0];
      p.zero_width  = 1'b1;
      return p;
    end
    reach = (x1 >= st) ? x1 - st : st - x1;
    if (y2 >= y1) begin
      q   = ((y2 - y1) * reach) / span;
      res = q + y1;
      if (res > 64'hFFFF) res = 64'hFFFF;
    end else begin
      q   = ((y1 - y2) * reach) / span;
      res = (q >= y1) ? 64'd0 : y1 - q;
    end
    p.curve_value = res[15:0];
    return p;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    curve_point_t want;
    if (!rst_n) begin
      scale_shift     = '0;
      fail_count      = 0;
      results_checked = 0;
      owed_q.delete();
    end else begin
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          note_fail($sformatf("unexpected result beat, got curve_value %0d zero_width %0b",
                              out_curve_value, out_zero_width_segment));
        end else begin
          want = owed_q.pop_front();
          results_checked++;
          if (out_curve_value !== want.curve_value)
            note_fail($sformatf("curve_value mismatch, expected %0d, got %0d",
                                want.curve_value, out_curve_value));
          if (out_zero_width_segment !== want.zero_width)
            note_fail($sformatf("zero_width_segment mismatch, expected %0b, got %0b",
                                want.zero_width, out_zero_width_segment));
        end
      end
      if (cfg_we) scale_shift = cfg_wdata;
      if (push && !full) begin
        if (in_action == plce_pkg::OP_LOAD) begin
          // slots past the last knot are dropped by the block
          if (in_knot_slot < plce_pkg::NUM_KNOTS) begin
            knot_x[in_knot_slot] = in_knot_coord;
            knot_y[in_knot_slot] = in_knot_value;
          end
        end else begin
          owed_q.push_back(predict_curve(in_target));
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ----- tb/piecewise_linear_curve_eval_test.sv -----
// Top of the curve evaluator testbench: clock, reset, stimulus and verdict.
// Depends on plce_pkg, piecewise_linear_curve_eval and plce_curve_checker.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_test;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 98;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 900000;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [3:0]  cfg_wdata     = '0;
  logic        push          = 1'b0;
  logic        in_action     = 1'b0;
  logic [3:0]  in_knot_slot  = '0;
  logic [15:0] in_knot_coord = '0;
  logic [15:0] in_knot_value = '0;
  logic [31:0] in_target     = '0;
  logic        pop           = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] out_curve_value;
  logic        out_zero_width_segment;

  int fail_count;
  int results_checked;
  int results_owed;

  // stimulus-side copy of the knot coordinates, used to aim targets and to place reloaded knots
  logic [15:0] kc [plce_pkg::NUM_KNOTS];
  logic [3:0]  scale_shift = '0;
  bit          in_steady   = 1'b0;
  bit          out_steady  = 1'b0;
  int          pop_wait    = 0;
  int          cycles      = 0;
  int          evals_sent  = 0;
  int          loads_sent  = 0;
  int          loads_dropped = 0;
  int          settings_used = 0;

  piecewise_linear_curve_eval u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .push                   (push),
    .full                   (full),
    .in_action              (in_action),
    .in_knot_slot           (in_knot_slot),
    .in_knot_coord          (in_knot_coord),
    .in_knot_value          (in_knot_value),
    .in_target              (in_target),
    .empty                  (empty),
    .pop                    (pop),
    .out_curve_value        (out_curve_value),
    .out_zero_width_segment (out_zero_width_segment)
  );

  plce_curve_checker u_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .push                   (push),
    .full                   (full),
    .in_action              (in_action),
    .in_knot_slot           (in_knot_slot),
    .in_knot_coord          (in_knot_coord),
    .in_knot_value          (in_knot_value),
    .in_target              (in_target),
    .empty                  (empty),
    .pop                    (pop),
    .out_curve_value        (out_curve_value),
    .out_zero_width_segment (out_zero_width_segment),
    .fail_count             (fail_count),
    .results_checked        (results_checked),
    .results_owed           (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, results_owed);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side: after each popped beat, stall for a gap from pick_gap unless out_steady
  always @(posedge clk) begin
    if (pop && !empty) pop_wait = out_steady ? 0 : pick_gap();
    else if (pop_wait > 0) pop_wait--;
    pop <= rst_n && (pop_wait == 0);
  end

  function automatic logic [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic longint unsigned knot_pos(input int i);
    return longint'(kc[i]) << scale_shift;
  endfunction

  // mostly inside a segment or on a knot, some clamps and some anywhere
  function automatic logic [31:0] pick_target();
    int              k;
    int unsigned     r;
    longint unsigned a, b, t;
    k = $urandom_range(0, plce_pkg::NUM_KNOTS - 2);
    a = knot_pos(k);
    b = knot_pos(k + 1);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    r = $urandom_range(0, 99);
    if (r < 60)      t = a + (longint'($urandom) % (b - a + 1));
    else if (r < 72) t = r[0] ? a : b;
    else if (r < 78) t = a + 1;
    else if (r < 86) t = $urandom_range(0, 32'(knot_pos(0)));
    else if (r < 93) t = knot_pos(plce_pkg::NUM_KNOTS - 1)
                         + $urandom_range(0, 32'd1 << $urandom_range(0, 31));
    else             t = $urandom;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return t[31:0];
  endfunction

  task automatic send_beat(input plce_pkg::op_t op, input logic [3:0] slot,
                           input logic [15:0] coord, input logic [15:0] value,
                           input logic [31:0] target);
    in_action     <= op;
    in_knot_slot  <= slot;
    in_knot_coord <= coord;
    in_knot_value <= value;
    in_target     <= target;
    push          <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_knot(input logic [3:0] slot, input logic [15:0] coord,
                           input logic [15:0] value);
    if (slot < plce_pkg::NUM_KNOTS) begin
      kc[slot] = coord;
      loads_sent++;
    end else begin
      loads_dropped++;
    end
    send_beat(plce_pkg::OP_LOAD, slot, coord, value, $urandom);
  endtask

  task automatic eval_at(input logic [31:0] target);
    evals_sent++;
    send_beat(plce_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), target);
  endtask

  // wait until every owed result is popped, then let loads still in the block finish
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scale(input logic [3:0] shift);
    drain();
    cfg_we      <= 1'b1;
    cfg_wdata   <= shift;
    scale_shift = shift;
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ordered curves keep segments well formed; the rest scatter the coordinates
  task automatic load_curve(input bit ordered);
    logic [15:0] nx [plce_pkg::NUM_KNOTS];
    logic [15:0] ny [plce_pkg::NUM_KNOTS];
    int          c;
    int          first;
    c = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000);
    for (int i = 0; i < plce_pkg::NUM_KNOTS; i++) begin
      if (ordered) begin
        nx[i] = 16'(c);
        c += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7000);
        if (c > 65535 || (i == plce_pkg::NUM_KNOTS - 2 && $urandom_range(0, 4) == 0))
          c = 65535;
      end else begin
        nx[i] = 16'($urandom);
      end
      ny[i] = pick_value();
    end
    first = $urandom_range(0, plce_pkg::NUM_KNOTS - 1);
    for (int i = 0; i < plce_pkg::NUM_KNOTS; i++) begin
      load_knot(4'((first + i) % plce_pkg::NUM_KNOTS), nx[(first + i) % plce_pkg::NUM_KNOTS],
                ny[(first + i) % plce_pkg::NUM_KNOTS]);
      pause(in_steady ? 0 : pick_gap());
    end
  endtask

  // rewrite one knot, usually between its neighbors so the curve stays ordered
  task automatic reload_knot();
    int k;
    int lo;
    int hi;
    k  = $urandom_range(0, plce_pkg::NUM_KNOTS - 1);
    lo = (k > 0) ? kc[k - 1] : 0;
    hi = (k < plce_pkg::NUM_KNOTS - 1) ? kc[k + 1] : 65535;
    if (lo <= hi && $urandom_range(0, 4) != 0)
      load_knot(4'(k), 16'($urandom_range(lo, hi)), pick_value());
    else
      load_knot(4'(k), 16'($urandom), pick_value());
  endtask

  initial begin
    logic [15:0] dir_x [plce_pkg::NUM_KNOTS];
    logic [15:0] dir_y [plce_pkg::NUM_KNOTS];
    int          n;
    int unsigned r;
    dir_x = '{16'd0, 16'd100, 16'd2000, 16'd2000, 16'd9000,
              16'd20000, 16'd30000, 16'd40000, 16'd60000, 16'd65535};
    dir_y = '{16'd65535, 16'd60000, 16'd100, 16'd5000, 16'd0,
              16'd65535, 16'd30000, 16'd30001, 16'd12, 16'd0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: scale at its reset value, knots at the field extremes
    for (int i = 0; i < plce_pkg::NUM_KNOTS; i++) load_knot(4'(i), dir_x[i], dir_y[i]);
    load_knot(4'd10, 16'h1234, 16'h4321);
    load_knot(4'd15, 16'hFFFF, 16'hFFFF);
    eval_at(32'd0);            // on the first knot
    eval_at(32'hFFFF_FFFF);    // far past the last knot
    eval_at(32'd65535);        // on the last knot
    eval_at(32'd2000);         // on a repeated coordinate
    eval_at(32'd50);           // falling first segment
    eval_at(32'd5000);         // falling segment after the repeat
    eval_at(32'd15000);        // rising full range
    eval_at(32'd35000);        // one-step rise
    eval_at(32'd62000);        // falling tail

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)      set_scale(4'd0);
      else if (ph == 1) set_scale(4'd15);
      else              set_scale(4'($urandom_range(0, 15)));
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      load_curve($urandom_range(0, 3) != 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 84) begin
          eval_at(pick_target());
          n++;
        end else if (r < 95) begin
          reload_knot();
          n++;
        end else begin
          load_knot(4'($urandom_range(plce_pkg::NUM_KNOTS, 15)), 16'($urandom),
                    16'($urandom));
        end
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
        else pause(in_steady ? 0 : pick_gap());
      end
    end

    drain();
    $display("Run covered %0d evaluates, %0d knot writes and %0d dropped writes",
             evals_sent, loads_sent, loads_dropped);
    $display("over %0d scale settings; %0d results checked with random gaps, %0d mismatches.",
             settings_used, results_checked, fail_count);
    if (fail_count == 0 && results_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/plce_pkg.sv
rtl/core/plce_div.sv
rtl/core/plce_front.sv
rtl/core/plce_back.sv
rtl/core/piecewise_linear_curve_eval.sv
rtl/core/plce_checker.sv
tb/plce_curve_checker.sv
tb/piecewise_linear_curve_eval_test.sv
